>>> rtl/mat_pkg.sv
package mat_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam logic [31:0] EXPIRY_RESET = 32'd300;

    localparam logic [1:0] STAGE_NONE = 2'd0;
    localparam logic [1:0] STAGE_1    = 2'd1;
    localparam logic [1:0] STAGE_2    = 2'd2;
    localparam logic [1:0] STAGE_3    = 2'd3;

    typedef enum logic [1:0] {
        KIND_SSH   = 2'd0,
        KIND_HTTP  = 2'd1,
        KIND_FTP   = 2'd2,
        KIND_OTHER = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_UNCHANGED = 3'd0,
        ST_ADDED     = 3'd1,
        ST_FULL      = 3'd2,
        ST_TO2       = 3'd3,
        ST_TO3       = 3'd4,
        ST_ATTACK    = 3'd5,
        ST_BADKIND   = 3'd6,
        ST_INVALID   = 3'd7
    } t_status;

    typedef struct packed {
        logic             valid;
        logic             act;
        t_kind            kind;
        logic [31:0]      ip;
        logic [31:0]      now;
        logic             hit;
        logic             live;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        t_status          status;
        logic [1:0]       stage;
    } t_tok;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [31:0]      ip;
        logic [31:0]      now;
    } t_wr;

endpackage

>>> rtl/mat_cell.sv
module mat_cell import mat_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_idx,
    input  logic [31:0]      i_expiry,
    input  t_tok             i_tok,
    input  t_wr              i_wr,
    output t_tok             o_tok
);

    logic        r_used;
    logic [31:0] r_ip;
    logic [1:0]  r_stage;
    logic [31:0] r_time;
    logic        r_tok_vld;
    t_tok        r_tok;

    logic        n_used;
    logic [31:0] n_ip;
    logic [1:0]  n_stage;
    logic [31:0] n_time;
    t_tok        n_tok;

    logic        scan;
    logic        match;
    logic [31:0] age;
    logic        expired;
    logic        wr_here;

    always_comb begin
        scan    = i_tok.valid && i_tok.act && !i_tok.hit;
        match   = scan && r_used && (r_ip == i_tok.ip);
        age     = i_tok.now - r_time;
        expired = age > i_expiry;
        wr_here = i_wr.en && (i_wr.idx == i_idx);

        n_tok   = i_tok;
        n_used  = r_used;
        n_ip    = r_ip;
        n_stage = r_stage;
        n_time  = r_time;

        if (match) begin
            n_tok.hit = 1'b1;
            if (expired) begin
                n_used = 1'b0;
            end else begin
                n_tok.live  = 1'b1;
                n_tok.stage = r_stage;
                case (i_tok.kind)
                    KIND_HTTP: begin
                        if (r_stage == STAGE_1) begin
                            n_stage      = STAGE_2;
                            n_tok.stage  = STAGE_2;
                            n_tok.status = ST_TO2;
                        end
                    end
                    KIND_FTP: begin
                        if (r_stage == STAGE_2) begin
                            n_stage      = STAGE_3;
                            n_tok.stage  = STAGE_3;
                            n_tok.status = ST_TO3;
                        end else if (r_stage == STAGE_3) begin
                            n_tok.status = ST_ATTACK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (i_tok.valid && !i_tok.free_found && (!r_used || (match && expired))) begin
            n_tok.free_found = 1'b1;
            n_tok.free_idx   = i_idx;
        end

        if (wr_here) begin
            n_used  = 1'b1;
            n_ip    = i_wr.ip;
            n_stage = STAGE_1;
            n_time  = i_wr.now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= 1'b0;
            r_tok_vld <= 1'b0;
        end else begin
            r_used    <= n_used;
            r_tok_vld <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ip    <= n_ip;
        r_stage <= n_stage;
        r_time  <= n_time;
        r_tok   <= n_tok;
    end

    always_comb begin
        o_tok       = r_tok;
        o_tok.valid = r_tok_vld;
    end

endmodule

>>> rtl/multistep_attack_tracker_top.sv
// the request is registered in the head register, then the token walks the
// 16-cell chain one cell per cycle, and the result is registered after the last
// cell; a new item is accepted only once busy has fallen, so items do not overlap
// busy stays high until the result is registered; the receiver cannot stall
// reset (synchronous, active low) empties the table and loads expiry with 300
module multistep_attack_tracker_top import mat_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic        i_valid_req,
    input  logic [31:0] i_ip,
    input  logic [31:0] i_now_sec,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output logic        o_strobe,
    output logic [2:0]  o_status,
    output logic [1:0]  o_stage
);

    logic        r_busy;
    logic        r_head_vld;
    t_tok        r_head;
    logic [31:0] r_expiry;
    logic        r_strobe;
    t_status     r_status;
    logic [1:0]  r_stage;

    t_tok        n_head;
    t_status     n_status;
    logic [1:0]  n_stage;
    t_wr         w_wr;
    logic        accept;

    t_tok        w_tok [0:TABLE_ENTRIES];
    t_tok        w_tail;

    assign accept = start && !r_busy;

    always_comb begin
        w_tok[0]       = r_head;
        w_tok[0].valid = r_head_vld;
    end

    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        mat_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_idx    (IDX_W'(k)),
            .i_expiry (r_expiry),
            .i_tok    (w_tok[k]),
            .i_wr     (w_wr),
            .o_tok    (w_tok[k+1])
        );
    end

    assign w_tail = w_tok[TABLE_ENTRIES];

    always_comb begin
        n_head            = '0;
        n_head.valid      = 1'b1;
        n_head.kind       = t_kind'(i_kind);
        n_head.ip         = i_ip;
        n_head.now        = i_now_sec;
        n_head.stage      = STAGE_NONE;
        if (!i_valid_req) begin
            n_head.status = ST_INVALID;
        end else if (t_kind'(i_kind) == KIND_OTHER) begin
            n_head.status = ST_BADKIND;
        end else begin
            n_head.status = ST_UNCHANGED;
            n_head.act    = 1'b1;
        end
    end

    // commit at the end of the chain, insert goes back to the chosen cell
    always_comb begin
        n_status = w_tail.status;
        n_stage  = w_tail.stage;
        w_wr.en  = 1'b0;
        w_wr.idx = w_tail.free_idx;
        w_wr.ip  = w_tail.ip;
        w_wr.now = w_tail.now;
        if (w_tail.act && (w_tail.kind == KIND_SSH) && !w_tail.live) begin
            if (w_tail.free_found) begin
                w_wr.en  = w_tail.valid;
                n_status = ST_ADDED;
                n_stage  = STAGE_1;
            end else begin
                n_status = ST_FULL;
                n_stage  = STAGE_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_head_vld <= 1'b0;
            r_strobe   <= 1'b0;
            r_expiry   <= EXPIRY_RESET;
        end else begin
            r_head_vld <= accept;
            r_strobe   <= w_tail.valid;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (w_tail.valid) begin
                r_busy <= 1'b0;
            end
            if (i_cfg_we) begin
                r_expiry <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_head <= n_head;
        end
        if (w_tail.valid) begin
            r_status <= n_status;
            r_stage  <= n_stage;
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_status = r_status;
    assign o_stage  = r_stage;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_busy)
        else $error("busy not raised after transfer");

    a_tail_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.valid |=> o_strobe)
        else $error("chain tail gave no result");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !r_busy && !r_head_vld)
        else $error("result while item still in flight");

    a_added_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ST_ADDED)) |-> (o_stage == STAGE_1))
        else $error("added record not at stage 1");

    a_attack_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ST_ATTACK)) |-> (o_stage == STAGE_3))
        else $error("attack reported off stage 3");
`endif

endmodule
